@@ rtl/qsm3_pkg.sv @@
// shared constants, state encoding and helpers for the median-of-three quicksort block
// no dependencies
package qsm3_pkg;

  localparam int unsigned MAX_ELEMENTS = 64;
  localparam int unsigned ELEM_W       = 64;
  localparam int unsigned IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int unsigned CNT_W        = IDX_W + 1;
  localparam int unsigned STACK_DEPTH  = 64;
  localparam int unsigned SP_W         = $clog2(STACK_DEPTH) + 1;
  localparam int unsigned STACK_LIM    = MAX_ELEMENTS / 2;
  localparam int unsigned RANGE_W      = 2 * IDX_W;
  localparam int unsigned OPS_W        = 20;
  localparam logic [OPS_W-1:0] OPS_MAX    = {OPS_W{1'b1}};
  localparam logic [OPS_W-1:0] SWAP_MOVES = OPS_W'(3);
  localparam logic [OPS_W-1:0] ONE_OP     = OPS_W'(1);
  localparam int unsigned OUT_DATA_W   = 112;

  typedef enum logic [4:0] {
    ST_LOAD, ST_POP, ST_RNG, ST_RD_LO, ST_RD_MID, ST_RD_HI, ST_RD_END,
    ST_C1, ST_C2, ST_C3, ST_W1, ST_W2, ST_W3,
    ST_PI_CHK, ST_PI_CMP, ST_PJ_PRE, ST_PJ_CHK, ST_PJ_CMP,
    ST_DECIDE, ST_SWAP2, ST_PUSH_HI, ST_PUSH_LO,
    ST_OUT_RD, ST_OUT_LD, ST_OUT_HOLD
  } state_e;

  // saturating counter add
  function automatic logic [OPS_W-1:0] sat_add(input logic [OPS_W-1:0] c,
                                               input logic [OPS_W-1:0] k);
    logic [OPS_W:0] s;
    s = {1'b0, c} + {1'b0, k};
    return s[OPS_W] ? OPS_MAX : s[OPS_W-1:0];
  endfunction

  // signed less-than
  function automatic logic lt(input logic [ELEM_W-1:0] x, input logic [ELEM_W-1:0] y);
    return $signed(x) < $signed(y);
  endfunction

endpackage

@@ rtl/qsm3_ram.sv @@
// generic simple dual-port ram, one write and one registered read port
// no dependencies
module qsm3_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/quicksort_median_three_with_counts.sv @@
// top level: load, in-place quicksort over a ram and sorted streaming output
// depends on qsm3_pkg and qsm3_ram
//
// Elements (signed 64 bit) stream in one word per cycle on the slave side until a
// word with tlast, which is stored too and starts the sort. Up to MAX_ELEMENTS
// words are kept; further words are dropped and flagged. The array is sorted in
// place in a single-ported-read element ram: every range popped from a small
// range-stack ram gets its low, middle and high elements ordered (three
// comparisons, three moves per swap), the median moved to the front, and a Hoare
// partition; subranges go back onto the stack. Each element read takes an issue
// state and a compare state because the element ram has one registered read
// port. The result then streams out ascending, tlast on the final one, with the
// saturating comparison and move counts and the overflow flag on every word;
// each word is read from the element ram only after the one before is taken.
// No new word is taken from the end of loading until the last result is taken.
module quicksort_median_three_with_counts
  import qsm3_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // element_value [63:0]
  input  logic [ELEM_W-1:0]     s_axis_tdata,
  // last_item
  input  logic                  s_axis_tlast,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // sorted_value [63:0], comparison_count [83:64], move_count [103:84],
  // overflow_flag [104], zero [111:105]
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // run_end
  output logic                  m_axis_tlast
);

  // control state
  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;        // words loaded
  logic [CNT_W-1:0] n_q, n_d;            // words in this sort
  logic [SP_W-1:0]  sp_q, sp_d;          // range stack pointer
  logic [OPS_W-1:0] cmp_q, cmp_d;
  logic [OPS_W-1:0] mov_q, mov_d;
  logic             drop_q, drop_d;
  logic             tvalid_q, tvalid_d;
  logic             first_q, first_d;

  // datapath
  logic [IDX_W-1:0]  lo_q, lo_d, hi_q, hi_d, mid_q, mid_d;
  logic [IDX_W-1:0]  i_q, i_d, j_q, j_d, k_q, k_d;
  logic [ELEM_W-1:0] vl_q, vl_d, vm_q, vm_d, vh_q, vh_d;
  logic [ELEM_W-1:0] vi_q, vi_d, vj_q, vj_d, piv_q, piv_d;
  logic [ELEM_W-1:0] oval_q, oval_d;
  logic              olast_q, olast_d;

  // memory ports
  logic               mem_we;
  logic [IDX_W-1:0]   mem_waddr, mem_raddr;
  logic [ELEM_W-1:0]  mem_wdata, mem_rdata;
  logic               stk_we;
  logic [SP_W-2:0]    stk_waddr, stk_raddr;
  logic [RANGE_W-1:0] stk_wdata, stk_rdata;

  logic [CNT_W-1:0] n_m1;
  logic [CNT_W-1:0] j_p1;
  logic [SP_W-1:0]  sp_m1;

  assign n_m1  = cnt_d - CNT_W'(1);
  assign j_p1  = {1'b0, j_q} + CNT_W'(1);
  assign sp_m1 = sp_q - SP_W'(1);

  qsm3_ram #(.WIDTH(ELEM_W), .DEPTH(MAX_ELEMENTS)) u_elem_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  qsm3_ram #(.WIDTH(RANGE_W), .DEPTH(STACK_DEPTH)) u_stack_ram (
    .clk_i  (clk_i),
    .we_i   (stk_we),
    .waddr_i(stk_waddr),
    .wdata_i(stk_wdata),
    .raddr_i(stk_raddr),
    .rdata_o(stk_rdata)
  );

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    n_d      = n_q;
    sp_d     = sp_q;
    cmp_d    = cmp_q;
    mov_d    = mov_q;
    drop_d   = drop_q;
    tvalid_d = tvalid_q;
    first_d  = first_q;
    lo_d = lo_q; hi_d = hi_q; mid_d = mid_q;
    i_d  = i_q;  j_d  = j_q;  k_d   = k_q;
    vl_d = vl_q; vm_d = vm_q; vh_d  = vh_q;
    vi_d = vi_q; vj_d = vj_q; piv_d = piv_q;
    oval_d  = oval_q;
    olast_d = olast_q;
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = '0;
    mem_raddr = '0;
    stk_we    = 1'b0;
    stk_waddr = sp_q[SP_W-2:0];
    stk_wdata = '0;
    stk_raddr = '0;

    unique case (state_q)
      ST_LOAD: begin
        if (s_axis_tvalid) begin
          if (cnt_q < CNT_W'(MAX_ELEMENTS)) begin
            mem_we    = 1'b1;
            mem_waddr = cnt_q[IDX_W-1:0];
            mem_wdata = s_axis_tdata;
            cnt_d     = cnt_q + CNT_W'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (s_axis_tlast) begin
            n_d   = cnt_d;
            cmp_d = '0;
            mov_d = '0;
            sp_d  = '0;
            if (cnt_d > CNT_W'(1)) begin
              // whole array is the first range
              stk_we    = 1'b1;
              stk_waddr = '0;
              stk_wdata = {IDX_W'(0), n_m1[IDX_W-1:0]};
              sp_d      = SP_W'(1);
            end
            state_d = ST_POP;
          end
        end
      end
      ST_POP: begin
        if (sp_q == '0) begin
          k_d     = '0;
          state_d = ST_OUT_RD;
        end else begin
          sp_d      = sp_m1;
          stk_raddr = sp_m1[SP_W-2:0];
          state_d   = ST_RNG;
        end
      end
      ST_RNG: begin
        lo_d  = stk_rdata[RANGE_W-1:IDX_W];
        hi_d  = stk_rdata[IDX_W-1:0];
        mid_d = lo_d + ((hi_d - lo_d) >> 1);
        if (lo_d >= hi_d || {1'b0, hi_d} >= n_q) begin
          state_d = ST_POP;
        end else begin
          state_d = ST_RD_LO;
        end
      end
      ST_RD_LO: begin
        mem_raddr = lo_q;
        state_d   = ST_RD_MID;
      end
      ST_RD_MID: begin
        mem_raddr = mid_q;
        vl_d      = mem_rdata;
        state_d   = ST_RD_HI;
      end
      ST_RD_HI: begin
        mem_raddr = hi_q;
        vm_d      = mem_rdata;
        state_d   = ST_RD_END;
      end
      ST_RD_END: begin
        vh_d    = mem_rdata;
        state_d = ST_C1;
      end
      ST_C1: begin
        cmp_d = sat_add(cmp_q, ONE_OP);
        if (lt(vm_q, vl_q)) begin
          vl_d  = vm_q;
          vm_d  = vl_q;
          mov_d = sat_add(mov_q, SWAP_MOVES);
        end
        state_d = ST_C2;
      end
      ST_C2: begin
        cmp_d = sat_add(cmp_q, ONE_OP);
        if (lt(vh_q, vl_q)) begin
          vl_d = vh_q;
          vh_d = vl_q;
          // middle aliases low on a two-element range
          if (mid_q == lo_q) begin
            vm_d = vh_q;
          end
          mov_d = sat_add(mov_q, SWAP_MOVES);
        end
        state_d = ST_C3;
      end
      ST_C3: begin
        cmp_d = sat_add(cmp_q, ONE_OP);
        if (lt(vh_q, vm_q)) begin
          vm_d  = vh_q;
          vh_d  = vm_q;
          mov_d = sat_add(mov_q, SWAP_MOVES);
        end
        state_d = ST_W1;
      end
      ST_W1: begin
        // median goes to front, old low to middle
        mem_we    = 1'b1;
        mem_waddr = mid_q;
        mem_wdata = vl_q;
        state_d   = ST_W2;
      end
      ST_W2: begin
        mem_we    = 1'b1;
        mem_waddr = lo_q;
        mem_wdata = vm_q;
        if (mid_q != lo_q) begin
          mov_d = sat_add(mov_q, SWAP_MOVES);
        end
        state_d = ST_W3;
      end
      ST_W3: begin
        mem_we    = 1'b1;
        mem_waddr = hi_q;
        mem_wdata = vh_q;
        piv_d     = vm_q;
        mov_d     = sat_add(mov_q, ONE_OP);
        i_d       = lo_q;
        j_d       = hi_q;
        first_d   = 1'b1;
        state_d   = ST_PI_CHK;
      end
      ST_PI_CHK: begin
        cmp_d = sat_add(cmp_q, ONE_OP);
        if (i_q >= hi_q) begin
          state_d = ST_PJ_PRE;
        end else begin
          mem_raddr = i_q;
          state_d   = ST_PI_CMP;
        end
      end
      ST_PI_CMP: begin
        if (lt(mem_rdata, piv_q)) begin
          i_d     = i_q + IDX_W'(1);
          state_d = ST_PI_CHK;
        end else begin
          vi_d    = mem_rdata;
          state_d = ST_PJ_PRE;
        end
      end
      ST_PJ_PRE: begin
        if (!first_q && j_q > lo_q) begin
          j_d = j_q - IDX_W'(1);
        end
        state_d = ST_PJ_CHK;
      end
      ST_PJ_CHK: begin
        cmp_d = sat_add(cmp_q, ONE_OP);
        if (j_q <= lo_q) begin
          state_d = ST_DECIDE;
        end else begin
          mem_raddr = j_q;
          state_d   = ST_PJ_CMP;
        end
      end
      ST_PJ_CMP: begin
        if (lt(piv_q, mem_rdata)) begin
          j_d     = j_q - IDX_W'(1);
          state_d = ST_PJ_CHK;
        end else begin
          vj_d    = mem_rdata;
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (i_q >= j_q) begin
          state_d = ST_PUSH_HI;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = i_q;
          mem_wdata = vj_q;
          state_d   = ST_SWAP2;
        end
      end
      ST_SWAP2: begin
        mem_we    = 1'b1;
        mem_waddr = j_q;
        mem_wdata = vi_q;
        mov_d     = sat_add(mov_q, SWAP_MOVES);
        first_d   = 1'b0;
        i_d       = i_q + IDX_W'(1);
        state_d   = ST_PI_CHK;
      end
      ST_PUSH_HI: begin
        if (j_p1 < {1'b0, hi_q} && sp_q < SP_W'(STACK_DEPTH)) begin
          stk_we    = 1'b1;
          stk_wdata = {j_p1[IDX_W-1:0], hi_q};
          sp_d      = sp_q + SP_W'(1);
        end
        state_d = ST_PUSH_LO;
      end
      ST_PUSH_LO: begin
        if (lo_q < j_q && sp_q < SP_W'(STACK_DEPTH)) begin
          stk_we    = 1'b1;
          stk_wdata = {lo_q, j_q};
          sp_d      = sp_q + SP_W'(1);
        end
        state_d = ST_POP;
      end
      ST_OUT_RD: begin
        mem_raddr = k_q;
        state_d   = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        oval_d   = mem_rdata;
        olast_d  = ({1'b0, k_q} + CNT_W'(1)) == n_q;
        tvalid_d = 1'b1;
        state_d  = ST_OUT_HOLD;
      end
      ST_OUT_HOLD: begin
        if (m_axis_tready) begin
          tvalid_d = 1'b0;
          if (olast_q) begin
            // run done, ready for the next array
            cnt_d   = '0;
            cmp_d   = '0;
            mov_d   = '0;
            drop_d  = 1'b0;
            sp_d    = '0;
            state_d = ST_LOAD;
          end else begin
            k_d     = k_q + IDX_W'(1);
            state_d = ST_OUT_RD;
          end
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_LOAD;
      cnt_q    <= '0;
      n_q      <= '0;
      sp_q     <= '0;
      cmp_q    <= '0;
      mov_q    <= '0;
      drop_q   <= 1'b0;
      tvalid_q <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      n_q      <= n_d;
      sp_q     <= sp_d;
      cmp_q    <= cmp_d;
      mov_q    <= mov_d;
      drop_q   <= drop_d;
      tvalid_q <= tvalid_d;
      first_q  <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; mid_q <= mid_d;
    i_q  <= i_d;  j_q  <= j_d;  k_q   <= k_d;
    vl_q <= vl_d; vm_q <= vm_d; vh_q  <= vh_d;
    vi_q <= vi_d; vj_q <= vj_d; piv_q <= piv_d;
    oval_q  <= oval_d;
    olast_q <= olast_d;
  end

  assign s_axis_tready = (state_q == ST_LOAD);
  assign m_axis_tvalid = tvalid_q;
  assign m_axis_tlast  = olast_q;
  assign m_axis_tdata  = {{(OUT_DATA_W - ELEM_W - 2 * OPS_W - 1){1'b0}},
                          drop_q, mov_q, cmp_q, oval_q};

  // disjoint ranges of two or more elements bound the stack depth
  a_stack_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sp_q <= SP_W'(STACK_LIM))
    else $error("range stack deeper than expected");

  // an element is only compared below the range top on the left scan
  a_left_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PI_CMP) |-> (i_q < hi_q))
    else $error("left scan compared out of range");

  // right scan compares only above the range bottom
  a_right_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PJ_CMP) |-> (j_q > lo_q))
    else $error("right scan compared out of range");

  // counts never fall while a sort or its output is in progress
  a_counts_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_LOAD && $past(state_q) != ST_LOAD) |->
      (cmp_q >= $past(cmp_q) && mov_q >= $past(mov_q)))
    else $error("operation counters decreased during a sort");

endmodule

@@ sim/tb.sv @@
// testbench for the median-of-three quicksort block: random and directed arrays,
// scoreboard predicts sorted words with comparison and move counts
// depends on qsm3_pkg and quicksort_median_three_with_counts
`timescale 1ns / 100ps

module tb
  import qsm3_pkg::*;
();

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic              run_end;
    logic [OPS_W-1:0]  cmps;
    logic [OPS_W-1:0]  moves;
    logic              dropped;
  } sorted_word_t;

  int unsigned mismatch_count = 0;

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("MISMATCH at %0t: %s", $realtime, what);
  endtask

  // predicts the sorted stream of each array and checks the output against it
  class sort_scoreboard;
    logic [ELEM_W-1:0] arr[MAX_ELEMENTS];
    int unsigned       loaded;
    bit                dropped;
    logic [OPS_W-1:0]  cmps, moves;
    sorted_word_t      pending[$];

    function void bump(ref logic [OPS_W-1:0] c, input int unsigned k);
      c = (c + k > OPS_MAX) ? OPS_MAX : OPS_W'(c + k);
    endfunction

    function bit less(logic [ELEM_W-1:0] x, logic [ELEM_W-1:0] y);
      return $signed(x) < $signed(y);
    endfunction

    function void xchg(int unsigned x, int unsigned y);
      logic [ELEM_W-1:0] t;
      t = arr[x]; arr[x] = arr[y]; arr[y] = t;
      bump(moves, 3);
    endfunction

    function int unsigned partition(int unsigned lo, int unsigned hi);
      int unsigned mid, i, j;
      logic [ELEM_W-1:0] pivot;
      bit first;
      mid = lo + (hi - lo) / 2;
      bump(cmps, 1); if (less(arr[mid], arr[lo])) xchg(lo, mid);
      bump(cmps, 1); if (less(arr[hi], arr[lo])) xchg(lo, hi);
      bump(cmps, 1); if (less(arr[hi], arr[mid])) xchg(mid, hi);
      if (mid != lo) xchg(lo, mid);
      pivot = arr[lo];
      bump(moves, 1);
      i = lo; j = hi; first = 1;
      forever begin
        if (!first) i++;
        forever begin
          bump(cmps, 1);
          if (i >= hi || !less(arr[i], pivot)) break;
          i++;
        end
        if (!first && j > lo) j--;
        forever begin
          bump(cmps, 1);
          if (j <= lo || !less(pivot, arr[j])) break;
          j--;
        end
        if (i >= j) return j;
        xchg(i, j);
        first = 0;
      end
    endfunction

    function void note_element(logic [ELEM_W-1:0] v, logic last);
      int unsigned stk_lo[$], stk_hi[$];
      int unsigned lo, hi, p;
      sorted_word_t w;
      if (loaded < MAX_ELEMENTS) arr[loaded++] = v;
      else dropped = 1;
      if (!last) return;
      cmps = '0; moves = '0;
      if (loaded > 1) begin stk_lo.push_back(0); stk_hi.push_back(loaded - 1); end
      while (stk_lo.size() > 0) begin
        lo = stk_lo.pop_back(); hi = stk_hi.pop_back();
        p = partition(lo, hi);
        if (p + 1 < hi) begin stk_lo.push_back(p + 1); stk_hi.push_back(hi); end
        if (lo < p) begin stk_lo.push_back(lo); stk_hi.push_back(p); end
      end
      for (int unsigned k = 0; k < loaded; k++) begin
        w.value = arr[k]; w.run_end = (k + 1 == loaded);
        w.cmps = cmps; w.moves = moves; w.dropped = dropped;
        pending.push_back(w);
      end
      loaded = 0; dropped = 0;
    endfunction

    task check_word(sorted_word_t got);
      sorted_word_t exp_w;
      if (pending.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", got.value));
        return;
      end
      exp_w = pending.pop_front();
      if (got.value !== exp_w.value)
        report_mismatch($sformatf("value %h exp %h", got.value, exp_w.value));
      if (got.run_end !== exp_w.run_end)
        report_mismatch($sformatf("tlast %b exp %b", got.run_end, exp_w.run_end));
      if (got.cmps !== exp_w.cmps)
        report_mismatch($sformatf("cmps %0d exp %0d", got.cmps, exp_w.cmps));
      if (got.moves !== exp_w.moves)
        report_mismatch($sformatf("moves %0d exp %0d", got.moves, exp_w.moves));
      if (got.dropped !== exp_w.dropped)
        report_mismatch($sformatf("overflow %b exp %b", got.dropped, exp_w.dropped));
    endtask
  endclass

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [ELEM_W-1:0]     s_axis_tdata = '0;
  logic                  s_axis_tlast = 0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tlast;

  sort_scoreboard sb = new();
  bit sending_done = 0;

  always #2 clk_i = ~clk_i;

  quicksort_median_three_with_counts dut (.*);

  // one element word, with a random gap first; valid stays up between
  // back-to-back words and drops only for a gap
  task automatic send_element(input logic [ELEM_W-1:0] v, input logic last);
    int unsigned gap;
    gap = $urandom_range(0, 6);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_axis_tvalid <= 0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1; s_axis_tdata <= v; s_axis_tlast <= last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_element(v, last);
    @(negedge clk_i);
  endtask

  function automatic logic [ELEM_W-1:0] rand_elem(input int unsigned mode);
    case (mode)
      0: return {$urandom, $urandom};
      1: return ELEM_W'($signed($urandom_range(0, 8)) - 4);
      2: return $urandom_range(0, 1) ? {1'b1, {ELEM_W-1{1'b0}}} : {1'b0, {ELEM_W-1{1'b1}}};
      default: return {{32{1'b1}}, $urandom};
    endcase
  endfunction

  task automatic send_array(input int unsigned n, input int unsigned mode);
    for (int unsigned k = 0; k < n; k++)
      send_element(rand_elem(mode == 4 ? $urandom_range(0, 3) : mode), k + 1 == n);
  endtask

  // receiver: random stalls, compares every accepted word
  initial begin
    sorted_word_t got;
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
      if (stall > 0) begin
        m_axis_tready <= 0;
        repeat (stall) @(negedge clk_i);
      end
      m_axis_tready <= 1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.value = m_axis_tdata[63:0];
      got.cmps = m_axis_tdata[83:64];
      got.moves = m_axis_tdata[103:84];
      got.dropped = m_axis_tdata[104];
      got.run_end = m_axis_tlast;
      sb.check_word(got);
    end
  end

  initial begin
    repeat (8) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);
    // directed: single, pair, extremes, duplicates, sorted, sorted negatives
    send_element(64'h8000_0000_0000_0000, 1);
    send_element(64'h7fff_ffff_ffff_ffff, 0);
    send_element(64'h8000_0000_0000_0000, 1);
    send_array(3, 2);
    for (int k = 0; k < 5; k++) send_element(ELEM_W'(k), k == 4);
    for (int k = 5; k > 0; k--) send_element(ELEM_W'(-k), k == 1);
    send_array(6, 1);
    // wait until drained
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(negedge clk_i);
    // capacity: 70 words, last six dropped, last one still starts the sort
    send_array(MAX_ELEMENTS + 6, 4);
    for (int r = 0; r < 24; r++) begin
      if (r == 12) send_array(MAX_ELEMENTS, 4);
      else send_array($urandom_range(1, 10), $urandom_range(0, 4));
    end
    s_axis_tvalid <= 0;
    sending_done = 1;
  end

  initial begin
    wait (sending_done);
    while (sb.pending.size() != 0) @(negedge clk_i);
    repeat (200) @(negedge clk_i);
    if (mismatch_count == 0 && sb.pending.size() == 0)
      $display("quicksort_median_three_with_counts test passed");
    else
      $display("quicksort_median_three_with_counts test failed");
    $finish;
  end

  initial begin
    #8ms;
    $display("quicksort_median_three_with_counts test failed");
    $finish;
  end

endmodule

@@ files.f @@
rtl/qsm3_pkg.sv
rtl/qsm3_ram.sv
rtl/quicksort_median_three_with_counts.sv
sim/tb.sv
